@@ hdl/max_sum_square_window_macros.svh @@
// Assertion macros shared by the max-sum square window block.
`ifndef MAX_SUM_SQUARE_WINDOW_MACROS_SVH
`define MAX_SUM_SQUARE_WINDOW_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define MSSW_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("mssw: same-cycle check failed");

// Antecedent implies consequent in the next cycle.
`define MSSW_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("mssw: next-cycle check failed");

`endif

@@ hdl/mssw_pkg.sv @@
// Shared types and constants for the max-sum square window block.
package mssw_pkg;

  localparam int DEFAULT_MAX_DIM = 32;

  // field widths
  localparam int ELEM_W  = 16;
  localparam int WSIZE_W = 6;
  localparam int CFG_W   = 6;
  localparam int CFG_IDX_W = 2;
  localparam int SUM_W   = 25;
  localparam int POS_W   = 5;
  localparam int SIZE_W  = 6;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;

  // request kinds on tuser
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // input word: elem_value, window_size, padded to bytes
  localparam int S_TDATA_W = 24;
  localparam int ELEM_LO   = 0;
  localparam int WSIZE_LO  = ELEM_LO + ELEM_W;

  // output word: best_sum, best_row, best_col, best_size, found, size_ok
  localparam int M_TDATA_W = 48;
  localparam int SUM_LO    = 0;
  localparam int ROW_LO    = SUM_LO + SUM_W;
  localparam int COL_LO    = ROW_LO + POS_W;
  localparam int SIZE_LO   = COL_LO + POS_W;
  localparam int FOUND_BIT = SIZE_LO + SIZE_W;
  localparam int OK_BIT    = FOUND_BIT + 1;
  localparam int M_PAD_W   = M_TDATA_W - OK_BIT - 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LAST,
    ST_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_we;
    logic query_start;
    logic rd_issue;
    logic cmp_step;
    logic result_load;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic is_query;
    logic size_fits;
    logic rd_last;
    logic win_last;
    logic out_free;
  } status_t;

endpackage

@@ hdl/mssw_ctrl.sv @@
// Sequencer for loads, the window scan and result hand-off.
module mssw_ctrl import mssw_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output cmd_t    cmd,
  output logic    s_tready
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (status.in_valid && status.is_query) begin
          state_next = status.size_fits ? ST_READ : ST_DONE;
        end
      end
      ST_READ: begin
        if (status.rd_last) begin
          state_next = ST_LAST;
        end
      end
      ST_LAST: state_next = ST_CMP;
      ST_CMP: begin
        state_next = status.win_last ? ST_DONE : ST_READ;
      end
      ST_DONE: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready        = 1'b1;
        cmd.load_we     = status.in_valid && !status.is_query;
        cmd.query_start = status.in_valid && status.is_query;
      end
      ST_READ: cmd.rd_issue    = 1'b1;
      ST_LAST: cmd             = '0;
      ST_CMP:  cmd.cmp_step    = 1'b1;
      ST_DONE: cmd.result_load = status.out_free;
      default: cmd             = '0;
    endcase
  end

endmodule

@@ hdl/mssw_dp.sv @@
// Matrix store, load pointer, window scan counters, accumulator and best tracking.
module mssw_dp import mssw_pkg::*; #(
  parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output status_t              status,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 s_tvalid,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 s_tuser,
  output logic                 m_tvalid,
  output logic [M_TDATA_W-1:0] m_tdata,
  input  logic                 m_tready
);

  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int CNT_W  = $clog2(MAX_DIM + 1);
  localparam int CW1    = CNT_W + 1;
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ACC_W  = ELEM_W + 2 * IDX_W;
  localparam int CMP_W  = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

  // clamped matrix size
  logic [CNT_W-1:0] rows, cols;
  logic [CNT_W-1:0] cfg_clamped;

  always_comb begin
    if (cfg_data == '0) begin
      cfg_clamped = CNT_W'(1);
    end else if (CMP_W'(cfg_data) > CMP_W'(MAX_DIM)) begin
      cfg_clamped = CNT_W'(MAX_DIM);
    end else begin
      cfg_clamped = CNT_W'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= CNT_W'(1);
      cols <= CNT_W'(1);
    end else if (cfg_valid) begin
      if (cfg_index == REG_ROW_COUNT) begin
        rows <= cfg_clamped;
      end else if (cfg_index == REG_COL_COUNT) begin
        cols <= cfg_clamped;
      end
    end
  end

  // input word fields
  logic signed [ELEM_W-1:0] elem_value;
  logic [WSIZE_W-1:0]       window_size;
  logic                     fits;

  assign elem_value  = s_tdata[ELEM_LO +: ELEM_W];
  assign window_size = s_tdata[WSIZE_LO +: WSIZE_W];
  assign fits = (window_size != '0) &&
                (CMP_W'(window_size) <= CMP_W'(rows)) &&
                (CMP_W'(window_size) <= CMP_W'(cols));

  // load pointer, row-major with wrap at the current bounds
  logic [IDX_W-1:0] ld_row, ld_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      ld_row <= '0;
      ld_col <= '0;
    end else if (cmd.load_we) begin
      if (CW1'(ld_col) + CW1'(1) >= CW1'(cols)) begin
        ld_col <= '0;
        ld_row <= (CW1'(ld_row) + CW1'(1) >= CW1'(rows)) ? '0 : ld_row + IDX_W'(1);
      end else begin
        ld_col <= ld_col + IDX_W'(1);
      end
    end
  end

  // scan counters
  logic [CNT_W-1:0] side, side_m1;
  logic [IDX_W-1:0] top, left, dr, dc;
  logic             fits_q;
  logic             col_end, row_end;

  assign side_m1 = side - CNT_W'(1);
  assign col_end = (CW1'(left) + CW1'(side)) == CW1'(cols);
  assign row_end = (CW1'(top) + CW1'(side)) == CW1'(rows);

  always_ff @(posedge clk) begin
    if (rst) begin
      side   <= '0;
      fits_q <= 1'b0;
      top    <= '0;
      left   <= '0;
      dr     <= '0;
      dc     <= '0;
    end else if (cmd.query_start) begin
      side   <= CNT_W'(window_size);
      fits_q <= fits;
      top    <= '0;
      left   <= '0;
      dr     <= '0;
      dc     <= '0;
    end else begin
      if (cmd.rd_issue) begin
        if (CNT_W'(dc) == side_m1) begin
          dc <= '0;
          dr <= (CNT_W'(dr) == side_m1) ? '0 : dr + IDX_W'(1);
        end else begin
          dc <= dc + IDX_W'(1);
        end
      end
      if (cmd.cmp_step) begin
        if (col_end) begin
          left <= '0;
          top  <= top + IDX_W'(1);
        end else begin
          left <= left + IDX_W'(1);
        end
      end
    end
  end

  // matrix store: one write port for loads, one registered read port for the scan
  logic signed [ELEM_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0]        wr_addr, rd_addr;
  logic [IDX_W-1:0]         rd_row, rd_col;
  logic signed [ELEM_W-1:0] rd_data;
  logic                     rd_valid;

  assign rd_row  = IDX_W'(top + dr);
  assign rd_col  = IDX_W'(left + dc);
  assign wr_addr = ADDR_W'(ADDR_W'(ld_row) * ADDR_W'(MAX_DIM) + ADDR_W'(ld_col));
  assign rd_addr = ADDR_W'(ADDR_W'(rd_row) * ADDR_W'(MAX_DIM) + ADDR_W'(rd_col));

  always_ff @(posedge clk) begin
    if (cmd.load_we) begin
      mem[wr_addr] <= elem_value;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.rd_issue;
    end
  end

  // window sum
  logic signed [ACC_W-1:0] acc;

  always_ff @(posedge clk) begin
    if (rst || cmd.query_start || cmd.cmp_step) begin
      acc <= '0;
    end else if (rd_valid) begin
      acc <= acc + ACC_W'(rd_data);
    end
  end

  // best so far; stays non-negative, so one signed compare covers it
  logic signed [ACC_W-1:0] best;
  logic [IDX_W-1:0]        best_top, best_left;
  logic [CNT_W-1:0]        best_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      best      <= '0;
      best_top  <= '0;
      best_left <= '0;
      best_side <= '0;
    end else if (cmd.cmp_step && (acc > best)) begin
      best      <= acc;
      best_top  <= top;
      best_left <= left;
      best_side <= side;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.result_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      m_tdata <= {{M_PAD_W{1'b0}}, fits_q, (best_side != '0), SIZE_W'(best_side),
                  POS_W'(best_left), POS_W'(best_top), SUM_W'(best)};
    end
  end

  always_comb begin
    status           = '0;
    status.in_valid  = s_tvalid;
    status.is_query  = (s_tuser == REQ_QUERY);
    status.size_fits = fits;
    status.rd_last   = (CNT_W'(dr) == side_m1) && (CNT_W'(dc) == side_m1);
    status.win_last  = row_end && col_end;
    status.out_free  = !m_tvalid || m_tready;
  end

endmodule

@@ hdl/max_sum_square_window.sv @@
// Top level of the max-sum square window search block.
//
// Usage: set row_count (index 0) and col_count (index 1) on the cfg channel,
// then stream load words (tuser = 0) carrying matrix elements in row-major
// order, then query words (tuser = 1) carrying a window side. cfg_ready is
// always high; out-of-range sizes are clamped to 1..MAX_DIM.
// A load gives no result. A query answers with one
// output word holding the best window so far (sum, top row, left column,
// side), a found flag and size_ok. A side that does not fit skips the scan.
// A fitting side has W = (rows-side+1) * (cols-side+1) windows, scanned in
// turn: each window is summed by reading the matrix store one element per
// cycle through its single read port, followed by a drain step and a
// compare step. The result word turns valid in the same cycle that the
// next input word can be taken.
// No input is taken while a query is in progress. A finished result sits in
// the output register; loads are still taken while it waits, and a following
// query runs its scan but holds its result until the receiver takes the
// previous one. Reset clears the load position and the best window; the
// matrix store is not cleared and must be loaded before it is queried.
`include "max_sum_square_window_macros.svh"

module max_sum_square_window import mssw_pkg::*; #(
  parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // elem_value[15:0], window_size[21:16], zero pad
  input  logic                 s_tuser,   // req_type
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata    // best_sum[24:0], best_row[29:25],
                                          // best_col[34:30], best_size[40:35],
                                          // found[41], size_ok[42], zero pad
);

  cmd_t    cmd;
  status_t status;
  logic [SIZE_W-1:0] out_size;

  assign cfg_ready = 1'b1;
  assign out_size  = m_tdata[SIZE_LO +: SIZE_W];

  mssw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .status   (status),
    .cmd      (cmd),
    .s_tready (s_tready)
  );

  mssw_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tready  (m_tready)
  );

  // a new result never overwrites one the receiver has not taken
  `MSSW_ASSERT_IMPL(a_no_overwrite, clk, rst, cmd.result_load, !m_tvalid || m_tready)
  // the input side is closed while the store is being scanned
  `MSSW_ASSERT_IMPL(a_closed_in_scan, clk, rst, cmd.rd_issue, !s_tready)
  // found flag agrees with the reported window side
  `MSSW_ASSERT_IMPL(a_found_side, clk, rst, m_tvalid, m_tdata[FOUND_BIT] == (out_size != '0))
  // a load never produces a result
  `MSSW_ASSERT_NEXT(a_load_silent, clk, rst, s_tvalid && s_tready && (s_tuser == REQ_LOAD), !$rose(m_tvalid))

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the max-sum square window search block.
module tb_top;
  import mssw_pkg::*;

  localparam int DIM = DEFAULT_MAX_DIM;
  localparam int ELEM_MAX = 32767;
  localparam int ELEM_MIN = -32768;
  localparam int SCAN_CAP = 4000;  // longest scan, in cycles, that random queries may ask for
  localparam int IDLE_WAIT = 4;
  localparam int DRAIN_WAIT = 8;
  localparam int RANDOM_ITEMS = 900;
  localparam longint CYCLE_LIMIT = 20_000_000;
  // indexes past the two registers; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;

  typedef enum int {FILL_WIDE, FILL_NEG, FILL_NARROW} fill_t;

  typedef struct {
    logic [SUM_W-1:0]  sum;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [SIZE_W-1:0] size;
    logic              found;
    logic              size_ok;
  } window_best_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 s_tuser = REQ_LOAD;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  max_sum_square_window #(.MAX_DIM(DIM)) DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow copy of the block state
  logic signed [ELEM_W-1:0] shadow_mat [DIM*DIM];
  int unsigned              next_row = 0;
  int unsigned              next_col = 0;
  logic [CFG_W-1:0]         rows_reg = 1;
  logic [CFG_W-1:0]         cols_reg = 1;
  int unsigned              rec_sum = 0;
  int unsigned              rec_row = 0;
  int unsigned              rec_col = 0;
  int unsigned              rec_side = 0;
  window_best_t             best_q[$];

  int     err_count = 0;
  int     n_loads = 0;
  int     n_queries = 0;
  int     n_misfit = 0;
  int     n_records = 0;
  int     n_ties = 0;
  longint cycles = 0;
  bit     tx_gaps = 1'b0;
  bit     rx_gaps = 1'b0;
  int     rx_hold = 0;  // long receiver stall, set by a test
  int     rx_idle = 0;

  function automatic int unsigned eff_dim(logic [CFG_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > DIM) return DIM;
    return 32'(raw);
  endfunction

  function automatic int unsigned min_dim();
    int unsigned r, c;
    r = eff_dim(rows_reg);
    c = eff_dim(cols_reg);
    return (r < c) ? r : c;
  endfunction

  function automatic int unsigned scan_cost(int unsigned side);
    int unsigned r, c;
    r = eff_dim(rows_reg);
    c = eff_dim(cols_reg);
    if (side == 0 || side > r || side > c) return 2;
    return 2 + (r - side + 1) * (c - side + 1) * (side * side + 2);
  endfunction

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 85) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 120);
  endfunction

  function automatic int rand_elem(fill_t fill);
    case (fill)
      FILL_NEG:    return int'($urandom_range(0, 32868)) - 32768;
      FILL_NARROW: return int'($urandom_range(0, 400)) - 200;
      default:     return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  task automatic store_elem(logic signed [ELEM_W-1:0] v);
    int unsigned r, c;
    r = next_row % DIM;
    c = next_col % DIM;
    shadow_mat[r*DIM + c] = v;
    if (c + 1 >= eff_dim(cols_reg)) begin
      next_col = 0;
      next_row = (r + 1 >= eff_dim(rows_reg)) ? 0 : r + 1;
    end else begin
      next_col = c + 1;
      next_row = r;
    end
    n_loads++;
  endtask

  // scan every window of this side and push the answer the block must give
  task automatic scan_windows(int unsigned side);
    int unsigned  rows, cols, top, left, r, c;
    longint       acc;
    bit           fits;
    window_best_t res;
    rows = eff_dim(rows_reg);
    cols = eff_dim(cols_reg);
    fits = side >= 1 && side <= rows && side <= cols;
    if (fits) begin
      for (top = 0; top + side <= rows; top++) begin
        for (left = 0; left + side <= cols; left++) begin
          acc = 0;
          for (r = top; r < top + side; r++)
            for (c = left; c < left + side; c++)
              acc += longint'(shadow_mat[r*DIM + c]);
          if (acc > longint'(rec_sum)) begin
            rec_sum = 32'(acc);
            rec_row = top;
            rec_col = left;
            rec_side = side;
            n_records++;
          end else if (acc > 0 && acc == longint'(rec_sum)) begin
            n_ties++;
          end
        end
      end
    end else begin
      n_misfit++;
    end
    res.sum = SUM_W'(rec_sum);
    res.row = POS_W'(rec_row);
    res.col = POS_W'(rec_col);
    res.size = SIZE_W'(rec_side);
    res.found = rec_side != 0;
    res.size_ok = fits;
    best_q.push_back(res);
    n_queries++;
  endtask

  // called and returns at a falling edge; valid stays high for a following word
  task automatic send_word(logic kind, logic signed [ELEM_W-1:0] elem,
                           logic [WSIZE_W-1:0] side);
    int                   gap;
    logic [S_TDATA_W-1:0] word;
    gap = (tx_gaps && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    word = '0;
    word[ELEM_LO +: ELEM_W] = elem;
    word[WSIZE_LO +: WSIZE_W] = side;
    s_tdata <= word;
    s_tuser <= kind;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (kind == REQ_LOAD) store_elem(elem);
    else scan_windows(32'(side));
    @(negedge clk);
  endtask

  task automatic send_load(int v);
    send_word(REQ_LOAD, ELEM_W'(v), WSIZE_W'($urandom_range(0, 63)));
  endtask

  task automatic send_query(int unsigned side);
    send_word(REQ_QUERY, ELEM_W'($urandom_range(0, 65535)), WSIZE_W'(side));
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (best_q.size() != 0) @(negedge clk);
    repeat (IDLE_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    wait_idle();
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_ROW_COUNT) rows_reg = val;
    else if (idx == REG_COL_COUNT) cols_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Fill the whole rows x cols region from the current load position. Often one
  // window gets a sum just above, or equal to, the current best so that records
  // keep moving as the best climbs.
  task automatic load_matrix(fill_t fill, output int unsigned plant_side);
    int unsigned rows, cols, r, c, s, n, top, left, need, base, rem, k;
    longint      target;
    int          plan [DIM*DIM];
    bit          done [DIM*DIM];
    rows = eff_dim(rows_reg);
    cols = eff_dim(cols_reg);
    for (k = 0; k < DIM*DIM; k++) begin
      plan[k] = rand_elem(fill);
      done[k] = 1'b0;
    end
    plant_side = 0;
    if ($urandom_range(0, 99) < 70) begin
      s = $urandom_range(1, min_dim());
      while (s > 1 && scan_cost(s) > SCAN_CAP) s--;
      n = s * s;
      target = longint'(rec_sum) +
               (($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 3000));
      if (target <= longint'(n) * ELEM_MAX) begin
        base = 32'(target / n);
        rem = 32'(target % n);
        top = $urandom_range(0, rows - s);
        left = $urandom_range(0, cols - s);
        for (k = 0; k < n; k++)
          plan[(top + k / s) * DIM + left + k % s] = base + (k < rem);
        plant_side = s;
      end
    end
    need = rows * cols;
    while (need > 0) begin
      r = next_row % DIM;
      c = next_col % DIM;
      if (r < rows && c < cols) begin
        if (!done[r*DIM + c]) begin
          done[r*DIM + c] = 1'b1;
          need--;
        end
        send_load(plan[r*DIM + c]);
      end else begin
        send_load(rand_elem(fill));
      end
    end
  endtask

  function automatic int unsigned pick_side();
    int unsigned mn, s, k;
    mn = min_dim();
    k = $urandom_range(0, 99);
    if (k < 10) return 0;
    if (k < 25) return $urandom_range(mn + 1, 63);
    s = $urandom_range(1, (k < 30) ? 63 : mn);
    while (s > 1 && s <= mn && scan_cost(s) > SCAN_CAP) s--;
    return s;
  endfunction

  task automatic test_reset_state();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    send_load(ELEM_MIN);
    send_query(1);   // negative sum never wins
    send_query(0);
    send_query(63);
  endtask

  task automatic test_small_matrix();
    write_reg(REG_ROW_COUNT, CFG_W'(2));
    write_reg(REG_COL_COUNT, CFG_W'(2));
    send_load(ELEM_MAX);
    send_load(ELEM_MIN);
    send_load(1);
    send_load(5);
    send_query(1);
    send_query(2);
    send_query(3);
    // equal sum at the bottom right must not replace the top left record
    send_load(-1);
    send_load(0);
    send_load(0);
    send_load(ELEM_MAX);
    send_query(1);
    send_query(2);
  endtask

  task automatic test_register_bounds();
    write_reg(REG_ROW_COUNT, CFG_W'(0));
    write_reg(REG_COL_COUNT, CFG_W'(63));
    write_reg(REG_SPARE2, CFG_W'(63));
    write_reg(REG_SPARE3, CFG_W'(0));
    send_query(2);
    send_query(0);
  endtask

  task automatic test_random_phases();
    int unsigned start, k, rr, cc, plant, nq, q;
    fill_t       fill;
    start = n_loads + n_queries;
    while (n_loads + n_queries - start < RANDOM_ITEMS) begin
      k = $urandom_range(0, 99);
      if (k < 80) begin
        rr = $urandom_range(0, 6);
        cc = $urandom_range(0, 6);
      end else if (k < 98) begin
        rr = $urandom_range(1, 12);
        cc = $urandom_range(1, 12);
      end else begin
        rr = $urandom_range(0, 63);
        cc = $urandom_range(0, 63);
      end
      write_reg(REG_ROW_COUNT, CFG_W'(rr));
      write_reg(REG_COL_COUNT, CFG_W'(cc));
      if ($urandom_range(0, 9) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE2 : REG_SPARE3,
                  CFG_W'($urandom_range(0, 63)));
      tx_gaps = $urandom_range(0, 3) != 0;
      rx_gaps = $urandom_range(0, 3) != 0;
      fill = fill_t'($urandom_range(0, 2));
      load_matrix(fill, plant);
      nq = $urandom_range(3, 8);
      for (q = 0; q < nq; q++) begin
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 3)) send_load(rand_elem(fill));
        send_query((q == 0 && plant != 0) ? plant : pick_side());
      end
    end
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_output_stall();
    int unsigned plant, k;
    write_reg(REG_ROW_COUNT, CFG_W'(3));
    write_reg(REG_COL_COUNT, CFG_W'(4));
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    load_matrix(FILL_WIDE, plant);
    rx_hold = 400;
    for (k = 0; k < 8; k++) begin
      send_query($urandom_range(1, 3));
      send_load(rand_elem(FILL_WIDE));
    end
  endtask

  // all elements at the top value: the largest sum the block can report
  task automatic test_full_scale();
    int unsigned k;
    write_reg(REG_ROW_COUNT, CFG_W'(DIM));
    write_reg(REG_COL_COUNT, CFG_W'(DIM));
    tx_gaps = 1'b0;
    rx_gaps = 1'b1;
    for (k = 0; k < DIM*DIM; k++) send_load(ELEM_MAX);
    send_query(DIM);
    send_query(1);
    send_query(DIM + 1);
  endtask

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold--;
    end else if (rx_idle > 0) begin
      m_tready <= 1'b0;
      rx_idle--;
    end else begin
      m_tready <= 1'b1;
      if (rx_gaps && $urandom_range(0, 99) < 25) rx_idle = pick_gap();
    end
  end

  always @(posedge clk) begin
    window_best_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (best_q.size() == 0) begin
        $error("result word with no query pending");
        err_count++;
      end else begin
        want = best_q.pop_front();
        check_field("best_sum", 32'(want.sum), 32'(m_tdata[SUM_LO +: SUM_W]));
        check_field("best_row", 32'(want.row), 32'(m_tdata[ROW_LO +: POS_W]));
        check_field("best_col", 32'(want.col), 32'(m_tdata[COL_LO +: POS_W]));
        check_field("best_size", 32'(want.size), 32'(m_tdata[SIZE_LO +: SIZE_W]));
        check_field("found", 32'(want.found), 32'(m_tdata[FOUND_BIT]));
        check_field("size_ok", 32'(want.size_ok), 32'(m_tdata[OK_BIT]));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, best_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_small_matrix();
    test_register_bounds();
    test_random_phases();
    test_output_stall();
    test_full_scale();
    s_tvalid <= 1'b0;
    while (best_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    $display("Covered %0d element loads and %0d window queries, %0d of them with a bad size",
             n_loads, n_queries, n_misfit);
    $display("Best window moved %0d times, %0d equal sums kept the old one, final sum %0d",
             n_records, n_ties, rec_sum);
    if (err_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
